@@ rtl/cla_pkg.sv @@
// ----------------------------------------------------------------------------
// cla_pkg
// Shared types, codes and sizes for the console line assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package cla_pkg;

    localparam int LineSize = 64;   // line buffer size, 2..64
    localparam int CountW   = 6;    // stored character count width
    localparam int LimitW   = 7;    // read limit width

    // Result status codes
    localparam logic [2:0] StStored   = 3'd0;
    localparam logic [2:0] StErased   = 3'd1;
    localparam logic [2:0] StIgnored  = 3'd2;
    localparam logic [2:0] StComplete = 3'd3;
    localparam logic [2:0] StOverflow = 3'd4;
    localparam logic [2:0] StRefused  = 3'd5;
    localparam logic [2:0] StNoLine   = 3'd6;
    localparam logic [2:0] StLineChar = 3'd7;

    // Command kinds
    localparam logic KindByte = 1'b0;
    localparam logic KindRead = 1'b1;

    // Byte codes
    localparam logic [7:0] ChBs    = 8'h08;
    localparam logic [7:0] ChDel   = 8'h7F;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChFirst = 8'd32;
    localparam logic [7:0] ChLast  = 8'd126;

    typedef struct packed {
        logic              kind;
        logic [7:0]        rx_char;
        logic [LimitW-1:0] read_limit;
    } t_cmd;

    typedef struct packed {
        logic [2:0]        status;
        logic [6:0]        line_char;
        logic [CountW-1:0] line_length;
        logic              last;
        logic [15:0]       error_total;
    } t_result;

    typedef struct packed {
        logic is_eol;
        logic is_bs;
        logic is_print;
    } t_byte_class;

endpackage

`default_nettype wire

@@ rtl/console_line_assembler.sv @@
// ----------------------------------------------------------------------------
// console_line_assembler
// Gathers console bytes into one line and streams it out on request.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a rising edge with i_start high and o_busy
//   low. A byte command (kind 0) edits the line and gives one result beat
//   in the next cycle; o_busy stays low, so bytes may follow every cycle.
//   A read command (kind 1) on a waiting line streams min(count, limit-1)
//   characters, one beat per cycle; the beats come through the line
//   buffer read register and the output register; o_busy is high while
//   streaming and the buffer is read one entry a cycle (single read port).
//   An empty read or a refused read gives one beat in the next cycle.
//   Each result beat sits on o_result for one cycle, flagged by o_strobe;
//   last marks the final beat of a command. The receiver cannot stall.
//   line_length and error_total show the state after the command.
//   Reset (synchronous, active low) clears count, waiting flag, error
//   counter and control; the line buffer is not cleared and needs no pass.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_assembler (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire cla_pkg::t_cmd    i_cmd,
    output logic                  o_busy,
    output logic                  o_strobe,
    output cla_pkg::t_result      o_result
);

    localparam logic SIdle = 1'b0;
    localparam logic SRead = 1'b1;

    // Line buffer
    logic [6:0] r_mem [cla_pkg::LineSize];
    logic [6:0] r_mem_q;

    // Control and state
    logic                        r_state, n_state;
    logic [cla_pkg::CountW-1:0]  r_count, n_count;
    logic                        r_waiting, n_waiting;
    logic [15:0]                 r_err, n_err;
    logic [cla_pkg::CountW-1:0]  r_idx, n_idx;
    logic [cla_pkg::CountW-1:0]  r_n, n_n;

    // Output register
    logic                        r_out_valid, n_out_valid;
    logic [2:0]                  r_out_status, n_out_status;
    logic                        r_out_last, n_out_last;
    logic                        r_out_mem, n_out_mem;

    logic                        accept;
    logic                        mem_we;
    cla_pkg::t_byte_class        cls;
    logic [cla_pkg::LimitW-1:0]  limit_m1;
    logic [cla_pkg::CountW-1:0]  read_n;

    cla_byte_dec u_dec (
        .i_byte  (i_cmd.rx_char),
        .o_class (cls)
    );

    assign accept   = i_start && (r_state == SIdle);
    assign limit_m1 = i_cmd.read_limit - cla_pkg::LimitW'(1);
    // count < limit keeps the whole line, else limit-1 (below count, fits)
    assign read_n   = ({1'b0, r_count} < i_cmd.read_limit) ?
                      r_count : limit_m1[cla_pkg::CountW-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_waiting    = r_waiting;
        n_err        = r_err;
        n_idx        = r_idx;
        n_n          = r_n;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_last   = 1'b1;
        n_out_mem    = 1'b0;
        mem_we       = 1'b0;

        case (r_state)
            SIdle: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    if (i_cmd.kind == cla_pkg::KindByte) begin
                        if (r_waiting) begin
                            n_out_status = cla_pkg::StRefused;
                        end else if (cls.is_eol) begin
                            n_waiting    = 1'b1;
                            n_out_status = cla_pkg::StComplete;
                        end else if (cls.is_bs) begin
                            if (r_count == '0) begin
                                n_out_status = cla_pkg::StIgnored;
                            end else begin
                                n_count      = r_count - cla_pkg::CountW'(1);
                                n_out_status = cla_pkg::StErased;
                            end
                        end else if (!cls.is_print) begin
                            n_out_status = cla_pkg::StIgnored;
                        end else if (r_count >= cla_pkg::CountW'(cla_pkg::LineSize - 1)) begin
                            // line full: drop it and count the error
                            n_count      = '0;
                            n_waiting    = 1'b0;
                            n_err        = r_err + 16'd1;
                            n_out_status = cla_pkg::StOverflow;
                        end else begin
                            mem_we       = 1'b1;
                            n_count      = r_count + cla_pkg::CountW'(1);
                            n_out_status = cla_pkg::StStored;
                        end
                    end else if (!r_waiting || (i_cmd.read_limit == '0)) begin
                        n_out_status = cla_pkg::StNoLine;
                    end else begin
                        n_count   = '0;
                        n_waiting = 1'b0;
                        if (read_n == '0) begin
                            // nothing to read (empty line or limit one): one beat with a null character
                            n_out_status = cla_pkg::StLineChar;
                        end else begin
                            // stream from the buffer, beats come from r_mem_q
                            n_out_valid = 1'b0;
                            n_idx       = '0;
                            n_n         = read_n;
                            n_state     = SRead;
                        end
                    end
                end
            end
            SRead: begin
                n_out_valid  = 1'b1;
                n_out_status = cla_pkg::StLineChar;
                n_out_mem    = 1'b1;
                n_out_last   = (r_idx == (r_n - cla_pkg::CountW'(1)));
                n_idx        = r_idx + cla_pkg::CountW'(1);
                if (n_out_last) begin
                    n_state = SIdle;
                end
            end
            default: begin
                n_state = SIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SIdle;
            r_count     <= '0;
            r_waiting   <= 1'b0;
            r_err       <= '0;
            r_idx       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
            r_out_mem   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_waiting   <= n_waiting;
            r_err       <= n_err;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
            r_out_mem   <= n_out_mem;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // Line buffer: written on a stored byte, read while streaming
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count] <= i_cmd.rx_char[6:0];
        end
        r_mem_q <= r_mem[r_idx];
    end

    assign o_busy   = (r_state == SRead);
    assign o_strobe = r_out_valid;

    always_comb begin
        o_result.status      = r_out_status;
        o_result.line_char   = r_out_mem ? r_mem_q : 7'd0;
        o_result.line_length = r_count;
        o_result.last        = r_out_last;
        o_result.error_total = r_err;
    end

endmodule

`default_nettype wire

@@ rtl/cla_byte_dec.sv @@
// ----------------------------------------------------------------------------
// cla_byte_dec
// Sorts a received byte into line end, backspace, printable or other.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_byte_dec (
    input  wire logic [7:0]               i_byte,
    output cla_pkg::t_byte_class          o_class
);

    always_comb begin
        o_class.is_eol   = (i_byte == cla_pkg::ChCr) || (i_byte == cla_pkg::ChLf);
        o_class.is_bs    = (i_byte == cla_pkg::ChBs) || (i_byte == cla_pkg::ChDel);
        o_class.is_print = (i_byte >= cla_pkg::ChFirst) && (i_byte <= cla_pkg::ChLast);
    end

endmodule

`default_nettype wire

@@ rtl/cla_checker.sv @@
// ----------------------------------------------------------------------------
// cla_checker
// Port-level checks of the console line assembler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cla_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire cla_pkg::t_cmd    i_cmd,
    input  wire logic             o_busy,
    input  wire logic             o_strobe,
    input  wire cla_pkg::t_result o_result
);

    // a byte beat always answers in the next cycle with a single last beat
    a_byte_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_cmd.kind == cla_pkg::KindByte))
        |=> (o_strobe && o_result.last))
        else $error("byte command without its result beat");

    // each streaming cycle delivers one line character beat after it
    a_stream_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(o_busy) && $past(i_rst_n))
        |-> (o_strobe && (o_result.status == cla_pkg::StLineChar)))
        else $error("missing line character beat while streaming");

    // the stream ends with the last marker
    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> (o_strobe && o_result.last))
        else $error("stream ended without last beat");

    // a line read always leaves the line empty
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == cla_pkg::StLineChar))
        |-> (o_result.line_length == '0))
        else $error("line not cleared by read");

endmodule

bind console_line_assembler cla_checker u_cla_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_cmd    (i_cmd),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

@@ verif/console_line_assembler_tb.sv @@
// ----------------------------------------------------------------------------
// console_line_assembler_tb
// Self-checking bench for the console line assembler: a short table of
// directed commands and two long lines, then random line traffic under three sender idle
// profiles. Every beat is checked against its typed row or the in-bench line model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module console_line_assembler_tb;

    localparam int CycleLimit = 400000;   // generous; a correct run needs far fewer
    localparam int DirRows    = 25;
    localparam int FaultShown = 10;

    // One row of the directed table. Rows with want_typed carry the single
    // beat expected; the rest are predicted by the line model.
    typedef struct {
        cla_pkg::t_cmd    cmd;
        bit               want_typed;
        cla_pkg::t_result want;
    } t_row;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    cla_pkg::t_cmd    i_cmd   = '0;
    logic             o_busy;
    logic             o_strobe;
    cla_pkg::t_result o_result;

    console_line_assembler dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line model: own copy of the line buffer, count, waiting flag and
    // overflow counter. Beats for one command land in cmd_beats.
    // ------------------------------------------------------------------
    logic [6:0]                 line_buf [cla_pkg::LineSize];
    logic [cla_pkg::CountW-1:0] line_cnt  = '0;
    logic                       line_held = 1'b0;
    logic [15:0]                ovf_cnt   = '0;
    cla_pkg::t_result           cmd_beats [$];
    cla_pkg::t_result           beats_due [$];    // expected beats, oldest first

    int unsigned cmds_sent     = 0;
    int unsigned beats_checked = 0;
    int unsigned lines_read    = 0;
    int unsigned bytes_refused = 0;
    int unsigned fault_cnt     = 0;
    int unsigned cycle_cnt     = 0;

    function automatic cla_pkg::t_result make_beat(logic [2:0] st, logic [6:0] ch,
                                                   logic lst);
        cla_pkg::t_result b;
        b.status      = st;
        b.line_char   = ch;
        b.line_length = line_cnt;       // state after the command
        b.last        = lst;
        b.error_total = ovf_cnt;
        return b;
    endfunction

    task automatic line_model_step(input cla_pkg::t_cmd c);
        int unsigned n;
        logic [2:0]  st;
        cmd_beats.delete();
        if (c.kind == cla_pkg::KindByte) begin
            if (line_held) begin
                st = cla_pkg::StRefused;    // completed line still waiting
                bytes_refused++;
            end else if (c.rx_char == cla_pkg::ChCr || c.rx_char == cla_pkg::ChLf) begin
                line_held = 1'b1;
                st = cla_pkg::StComplete;
            end else if (c.rx_char == cla_pkg::ChBs || c.rx_char == cla_pkg::ChDel) begin
                if (line_cnt == 0) begin
                    st = cla_pkg::StIgnored;
                end else begin
                    line_cnt--;
                    st = cla_pkg::StErased;
                end
            end else if (c.rx_char < cla_pkg::ChFirst || c.rx_char > cla_pkg::ChLast) begin
                st = cla_pkg::StIgnored;
            end else if (line_cnt >= cla_pkg::LineSize - 1) begin
                // full line: drop it and count the overflow
                line_cnt  = '0;
                line_held = 1'b0;
                ovf_cnt++;
                st = cla_pkg::StOverflow;
            end else begin
                line_buf[line_cnt] = c.rx_char[6:0];
                line_cnt++;
                st = cla_pkg::StStored;
            end
            cmd_beats.push_back(make_beat(st, 7'd0, 1'b1));
        end else if (!line_held || c.read_limit == 0) begin
            cmd_beats.push_back(make_beat(cla_pkg::StNoLine, 7'd0, 1'b1));
        end else begin
            n = line_cnt;
            if (n >= c.read_limit) n = c.read_limit - 1;
            line_cnt  = '0;
            line_held = 1'b0;
            lines_read++;
            if (n == 0) begin
                cmd_beats.push_back(make_beat(cla_pkg::StLineChar, 7'd0, 1'b1));
            end else begin
                for (int unsigned k = 0; k < n; k++) begin
                    cmd_beats.push_back(make_beat(cla_pkg::StLineChar, line_buf[k],
                                                  k + 1 == n));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Command builders. Unused fields still get random bits.
    // ------------------------------------------------------------------
    function automatic cla_pkg::t_cmd byte_cmd(logic [7:0] ch);
        cla_pkg::t_cmd c;
        c.kind       = cla_pkg::KindByte;
        c.rx_char    = ch;
        c.read_limit = cla_pkg::LimitW'($urandom_range(127));
        return c;
    endfunction

    function automatic cla_pkg::t_cmd read_cmd(logic [cla_pkg::LimitW-1:0] lim);
        cla_pkg::t_cmd c;
        c.kind       = cla_pkg::KindRead;
        c.rx_char    = 8'($urandom_range(255));
        c.read_limit = lim;
        return c;
    endfunction

    function automatic t_row row(cla_pkg::t_cmd c, bit typed, logic [2:0] st,
                                 int unsigned len);
        t_row r;
        r.cmd              = c;
        r.want_typed       = typed;
        r.want.status      = st;
        r.want.line_char   = 7'd0;
        r.want.line_length = cla_pkg::CountW'(len);
        r.want.last        = 1'b1;
        r.want.error_total = 16'd0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Command driver. Holds i_start low for a random number of cycles,
    // then presents the beat until a rising edge sees o_busy low.
    // ------------------------------------------------------------------
    task automatic send_cmd(input cla_pkg::t_cmd c, input int unsigned idle_pct,
                            input bit typed, input cla_pkg::t_result want);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= c;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        // beat taken at this edge
        cmds_sent++;
        line_model_step(c);
        if (typed) beats_due.push_back(want);
        else foreach (cmd_beats[k]) beats_due.push_back(cmd_beats[k]);
    endtask

    // Typed line: edit_pct percent of the bytes are backspaces or
    // control/high bytes instead of printable characters; CR or LF ends it.
    task automatic send_line(input int unsigned n_chars, input int unsigned edit_pct,
                             input int unsigned idle_pct);
        int unsigned r;
        logic [7:0]  ch;
        for (int unsigned k = 0; k < n_chars; k++) begin
            r = $urandom_range(99);
            if (r < edit_pct / 2)
                ch = $urandom_range(1) ? cla_pkg::ChBs : cla_pkg::ChDel;
            else if (r < edit_pct)
                ch = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(128, 255));
            else
                ch = 8'($urandom_range(cla_pkg::ChFirst, cla_pkg::ChLast));
            send_cmd(byte_cmd(ch), idle_pct, 1'b0, '0);
        end
        send_cmd(byte_cmd($urandom_range(1) ? cla_pkg::ChCr : cla_pkg::ChLf),
                 idle_pct, 1'b0, '0);
    endtask

    // Sender stops until every expected beat has come back.
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (beats_due.size() != 0);
    endtask

    // Mostly well-formed traffic: a line, maybe a few refused bytes, then
    // usually a read with a random limit. The rest is raw random commands.
    task automatic run_phase(input int unsigned n_cmds, input int unsigned idle_pct);
        int unsigned                 stop_at;
        int unsigned                 r;
        int unsigned                 len;
        logic [cla_pkg::LimitW-1:0]  lim;
        cla_pkg::t_cmd               c;
        stop_at = cmds_sent + n_cmds;
        while (cmds_sent < stop_at) begin
            if ($urandom_range(99) < 70) begin
                r = $urandom_range(99);
                if (r < 60)      len = $urandom_range(8);
                else if (r < 85) len = $urandom_range(9, 40);
                else if (r < 95) len = $urandom_range(41, 62);
                else             len = $urandom_range(63, 66);   // may run into overflow
                send_line(len, 15, idle_pct);
                if ($urandom_range(99) < 30)
                    repeat ($urandom_range(1, 3))
                        send_cmd(byte_cmd(8'($urandom_range(255))), idle_pct, 1'b0, '0);
                if ($urandom_range(99) < 85) begin
                    r = $urandom_range(99);
                    if (r < 10)      lim = '0;
                    else if (r < 25) lim = cla_pkg::LimitW'($urandom_range(1, 3));
                    else if (r < 75) lim = cla_pkg::LimitW'($urandom_range(1, 64));
                    else             lim = cla_pkg::LimitW'($urandom_range(64, 127));
                    send_cmd(read_cmd(lim), idle_pct, 1'b0, '0);
                end
            end else begin
                c.kind       = 1'($urandom_range(1));
                c.rx_char    = 8'($urandom_range(255));
                c.read_limit = cla_pkg::LimitW'($urandom_range(127));
                send_cmd(c, idle_pct, 1'b0, '0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobed beat against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic log_fault(input string what);
        fault_cnt++;
        if (fault_cnt <= FaultShown) $display("FAULT @%0d: %s", cycle_cnt, what);
    endtask

    always @(posedge i_clk) begin
        cla_pkg::t_result want;
        if (i_rst_n && o_strobe) begin
            beats_checked++;
            if (beats_due.size() == 0) begin
                log_fault($sformatf("beat with nothing expected: st=%0d ch=%0d len=%0d",
                                    o_result.status, o_result.line_char,
                                    o_result.line_length));
            end else begin
                want = beats_due.pop_front();
                if (o_result.status      !== want.status      ||
                    o_result.line_char   !== want.line_char   ||
                    o_result.line_length !== want.line_length ||
                    o_result.last        !== want.last        ||
                    o_result.error_total !== want.error_total)
                    log_fault({
                        $sformatf("want st=%0d ch=%0d len=%0d last=%0d err=%0d, ",
                                  want.status, want.line_char, want.line_length,
                                  want.last, want.error_total),
                        $sformatf("got st=%0d ch=%0d len=%0d last=%0d err=%0d",
                                  o_result.status, o_result.line_char,
                                  o_result.line_length, o_result.last,
                                  o_result.error_total)});
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CycleLimit) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     cycle_cnt, beats_due.size());
            $display("[console_line_assembler] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_row dir_tab [DirRows];

        // Directed: reset state, byte classes, empty-line cases, limit
        // zero/one, erase, truncation and the all-ones limit.
        dir_tab = '{
            row(read_cmd(7'd5), 1, cla_pkg::StNoLine, 0),   // read, no line waiting
            row(byte_cmd(cla_pkg::ChBs), 1, cla_pkg::StIgnored, 0),  // bs on empty line
            row(byte_cmd(cla_pkg::ChDel), 1, cla_pkg::StIgnored, 0),
            row(byte_cmd(8'h1F), 1, cla_pkg::StIgnored, 0),   // control byte
            row(byte_cmd(8'h80), 1, cla_pkg::StIgnored, 0),   // high bytes
            row(byte_cmd(8'hFF), 1, cla_pkg::StIgnored, 0),
            row(byte_cmd(cla_pkg::ChCr), 1, cla_pkg::StComplete, 0),  // empty line
            row(byte_cmd(cla_pkg::ChFirst), 1, cla_pkg::StRefused, 0), // waiting
            row(read_cmd(7'd0), 1, cla_pkg::StNoLine, 0),   // limit zero keeps line
            row(read_cmd(7'd64), 1, cla_pkg::StLineChar, 0), // empty: one beat, char 0
            row(byte_cmd(cla_pkg::ChFirst), 1, cla_pkg::StStored, 1),
            row(byte_cmd(cla_pkg::ChLast), 1, cla_pkg::StStored, 2),
            row(byte_cmd(cla_pkg::ChDel), 1, cla_pkg::StErased, 1),
            row(byte_cmd(8'h41), 0, cla_pkg::StStored, 0),
            row(byte_cmd(cla_pkg::ChLf), 1, cla_pkg::StComplete, 2),
            row(read_cmd(7'd1), 1, cla_pkg::StLineChar, 0), // limit one reads empty
            row(byte_cmd(8'h78), 0, cla_pkg::StStored, 0),
            row(byte_cmd(8'h79), 0, cla_pkg::StStored, 0),
            row(byte_cmd(8'h7A), 0, cla_pkg::StStored, 0),
            row(byte_cmd(cla_pkg::ChCr), 1, cla_pkg::StComplete, 3),
            row(read_cmd(7'd3), 0, cla_pkg::StStored, 0),   // truncated to two chars
            row(byte_cmd(8'h00), 1, cla_pkg::StIgnored, 0),
            row(byte_cmd(8'h51), 0, cla_pkg::StStored, 0),
            row(byte_cmd(cla_pkg::ChLf), 1, cla_pkg::StComplete, 1),
            row(read_cmd(7'd127), 0, cla_pkg::StStored, 0)  // all limit bits set
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[k])
            send_cmd(dir_tab[k].cmd, 0, dir_tab[k].want_typed, dir_tab[k].want);
        drain();

        // Full 63-char line read whole (longest burst), then a line that
        // runs past the buffer and overflows before its end.
        send_line(cla_pkg::LineSize - 1, 0, 32);
        send_cmd(read_cmd(7'd64), 32, 1'b0, '0);
        send_line(cla_pkg::LineSize + 2, 0, 32);
        send_cmd(read_cmd(7'd127), 32, 1'b0, '0);

        run_phase(50, 32);
        drain();                        // sender waits out all results
        run_phase(50, 83);
        drain();
        run_phase(50, 0);
        drain();

        // tail: catch stray beats after the last expected one
        repeat (4) @(posedge i_clk);
        if (beats_due.size() != 0)
            log_fault($sformatf("%0d expected beats never came", beats_due.size()));

        $display("run covered %0d commands and %0d result beats: %0d lines read,",
                 cmds_sent, beats_checked, lines_read);
        $display("%0d bytes refused on a waiting line, %0d line overflows, %0d faults",
                 bytes_refused, ovf_cnt, fault_cnt);
        if (fault_cnt == 0)
            $display("[console_line_assembler] OK");
        else
            $display("[console_line_assembler] ERROR");
        $finish;
    end

endmodule
